FILE: rtl/core/parabolic_sar_tracker_macros.svh
// assertion macros for the parabolic sar tracker checker
`ifndef PARABOLIC_SAR_TRACKER_MACROS_SVH
`define PARABOLIC_SAR_TRACKER_MACROS_SVH

// checked only out of reset
`define PST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define PST_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/core/pst_pkg.sv
// types and constants shared by the parabolic sar tracker
`default_nettype none

package pst_pkg;

    localparam int PRICE_W   = 32;
    localparam int TIME_W    = 32;
    localparam int AF_W      = 17;
    localparam int AF_FRAC   = 16;
    localparam int CFG_IDX_W = 8;

    localparam logic [AF_W-1:0] AF_STEP_RESET = AF_W'(1311);
    localparam logic [AF_W-1:0] AF_MAX_RESET  = AF_W'(13107);

    localparam logic [CFG_IDX_W-1:0] CFG_AF_STEP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_AF_MAX  = CFG_IDX_W'(1);

    typedef struct packed {
        logic [PRICE_W-1:0] bar_high;
        logic [PRICE_W-1:0] bar_low;
        logic [TIME_W-1:0]  bar_time;
    } t_bar;

    typedef struct packed {
        logic               is_long;
        logic [PRICE_W-1:0] sar_value;
        logic [TIME_W-1:0]  out_time;
    } t_res;

    typedef struct packed {
        logic               started;
        logic               trend_long;
        logic [PRICE_W-1:0] stop_level;
        logic [PRICE_W-1:0] extreme_point;
        logic [AF_W-1:0]    accel_factor;
        logic [PRICE_W-1:0] prev_high;
        logic [PRICE_W-1:0] prev_low;
    } t_sar_state;

endpackage

`default_nettype wire

FILE: rtl/core/pst_step.sv
// one bar of the sar update: reversal test, ep/af update, step and clamps
`default_nettype none

module pst_step import pst_pkg::*; (
    input  wire t_sar_state      i_state,
    input  wire t_bar            i_bar,
    input  wire [AF_W-1:0]       i_af_step,
    input  wire [AF_W-1:0]       i_af_max,
    output t_sar_state           o_state,
    output t_res                 o_res
);

    localparam int PROD_W  = PRICE_W + AF_W;
    localparam int DELTA_W = PROD_W - AF_FRAC;

    logic [PRICE_W-1:0] h;
    logic [PRICE_W-1:0] l;
    logic [PRICE_W-1:0] hi_bound;
    logic [PRICE_W-1:0] lo_bound;
    logic               rev;
    logic               new_long;
    logic [PRICE_W-1:0] base;
    logic [PRICE_W-1:0] ep_new;
    logic [AF_W-1:0]    af_new;
    logic [AF_W:0]      af_sum;
    logic [AF_W-1:0]    af_grown;
    logic [PRICE_W-1:0] shown;
    logic               up;
    logic [PRICE_W-1:0] ep_gap;
    logic [PROD_W-1:0]  prod;
    logic [DELTA_W-1:0] delta;
    logic [DELTA_W:0]   sum;
    logic [PRICE_W-1:0] adv;
    logic [PRICE_W-1:0] clamped;

    always_comb begin
        h = i_bar.bar_high;
        l = i_bar.bar_low;
        hi_bound = (i_state.prev_high > h) ? i_state.prev_high : h;
        lo_bound = (i_state.prev_low < l) ? i_state.prev_low : l;

        af_sum   = {1'b0, i_state.accel_factor} + {1'b0, i_af_step};
        af_grown = (af_sum > {1'b0, i_af_max}) ? i_af_max : af_sum[AF_W-1:0];

        rev      = i_state.trend_long ? (l <= i_state.stop_level)
                                      : (h >= i_state.stop_level);
        new_long = i_state.trend_long ^ rev;

        if (rev) begin
            // jump to ep, held beyond the current and previous extremes
            if (i_state.trend_long) begin
                base = (i_state.extreme_point > hi_bound) ? i_state.extreme_point
                                                           : hi_bound;
                ep_new = l;
            end else begin
                base = (i_state.extreme_point < lo_bound) ? i_state.extreme_point
                                                           : lo_bound;
                ep_new = h;
            end
            af_new = i_af_step;
        end else begin
            base   = i_state.stop_level;
            ep_new = i_state.extreme_point;
            af_new = i_state.accel_factor;
            if (i_state.trend_long ? (h > i_state.extreme_point)
                                   : (l < i_state.extreme_point)) begin
                ep_new = i_state.trend_long ? h : l;
                af_new = af_grown;
            end
        end
        shown = base;

        // base + af * (ep - base), truncated toward zero, saturated
        up     = ep_new >= base;
        ep_gap = up ? (ep_new - base) : (base - ep_new);
        prod   = PROD_W'(af_new) * PROD_W'(ep_gap);
        delta  = prod[PROD_W-1:AF_FRAC];
        sum    = {1'b0, delta} + (DELTA_W+1)'(base);
        if (up) begin
            adv = (sum[DELTA_W:PRICE_W] != '0) ? '1 : sum[PRICE_W-1:0];
        end else begin
            adv = (delta >= DELTA_W'(base)) ? '0 : (base - delta[PRICE_W-1:0]);
        end

        // a long trend keeps the sar below the bars, a short one above
        if (new_long) begin
            clamped = (adv < lo_bound) ? adv : lo_bound;
        end else begin
            clamped = (adv > hi_bound) ? adv : hi_bound;
        end

        o_state.started   = 1'b1;
        o_state.prev_high = h;
        o_state.prev_low  = l;
        if (!i_state.started) begin
            o_state.trend_long    = 1'b1;
            o_state.stop_level    = l;
            o_state.extreme_point = h;
            o_state.accel_factor  = i_af_step;
            o_res.sar_value       = l;
        end else begin
            o_state.trend_long    = new_long;
            o_state.stop_level    = clamped;
            o_state.extreme_point = ep_new;
            o_state.accel_factor  = af_new;
            o_res.sar_value       = shown;
        end
        o_res.is_long  = o_state.trend_long;
        o_res.out_time = i_bar.bar_time;
    end

endmodule

`default_nettype wire

FILE: rtl/core/parabolic_sar_tracker.sv
// parabolic stop-and-reverse tracker top level
//
//   channel   dir   handshake                     payload
//   bar       in    i_bar_valid / o_bar_ready     i_bar (t_bar)
//   result    out   o_res_valid / i_res_ready     o_res (t_res)
//   config    in    i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// one bar per cycle sustained while results are taken; a result is offered after
// its bar passes the input register, then the sar update into the result register
// sar update loop (step multiply and clamps) closes through the state register
// a stalled result holds one bar in the input register, then back-pressures
// sync reset inits state, valids, af config, not payload; config is always ready
`default_nettype none

module parabolic_sar_tracker import pst_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_bar_valid,
    output logic                 o_bar_ready,
    input  wire t_bar            i_bar,
    output logic                 o_res_valid,
    input  wire                  i_res_ready,
    output t_res                 o_res,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [AF_W-1:0]       i_cfg_data
);

    logic       r_in_vld;
    t_bar       r_in;
    logic       r_out_vld;
    t_res       r_out;
    t_sar_state r_state;
    t_sar_state n_state;
    t_res       n_res;
    logic [AF_W-1:0] r_af_step;
    logic [AF_W-1:0] r_af_max;
    logic       move;

    assign move        = r_in_vld && (!r_out_vld || i_res_ready);
    assign o_bar_ready = !r_in_vld || move;
    assign o_res_valid = r_out_vld;
    assign o_res       = r_out;
    assign o_cfg_ready = 1'b1;

    pst_step u_step (
        .i_state   (r_state),
        .i_bar     (r_in),
        .i_af_step (r_af_step),
        .i_af_max  (r_af_max),
        .o_state   (n_state),
        .o_res     (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_af_step <= AF_STEP_RESET;
            r_af_max  <= AF_MAX_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_AF_STEP: r_af_step <= i_cfg_data;
                CFG_AF_MAX:  r_af_max  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '{started: 1'b0, trend_long: 1'b0, stop_level: '0,
                           extreme_point: '0, accel_factor: AF_STEP_RESET,
                           prev_high: '0, prev_low: '0};
        end else begin
            if (o_bar_ready) begin
                r_in_vld <= i_bar_valid;
            end
            if (move) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
            end else if (i_res_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_bar_ready && i_bar_valid) begin
            r_in <= i_bar;
        end
        if (move) begin
            r_out <= n_res;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/pst_checker.sv
// port-level checks for the parabolic sar tracker, bound to the top level
`default_nettype none

`include "parabolic_sar_tracker_macros.svh"

module pst_checker import pst_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_bar_valid,
    input  wire                  o_bar_ready,
    input  wire                  o_res_valid,
    input  wire                  i_res_ready,
    input  wire t_res            o_res
);

    logic bar_beat;
    assign bar_beat = i_bar_valid && o_bar_ready;

    // a result held back stays offered
    `PST_ASSERT(a_res_hold, o_res_valid && !i_res_ready |=> o_res_valid, "result dropped")
    // and keeps its payload
    `PST_ASSERT(a_res_stable, o_res_valid && !i_res_ready |=> $stable(o_res), "result changed")
    // reset empties the result register
    `PST_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_res_valid, "result after reset")
    // with nothing in flight no result can appear
    `PST_ASSERT(a_no_phantom, !o_res_valid && !$past(bar_beat) |=> !o_res_valid, "phantom result")

endmodule

bind parabolic_sar_tracker pst_checker u_pst_checker (.*);

`default_nettype wire
